@@ hdl/block_cache_lfu_refcount_macros.svh @@
// Assertion helpers used by block_cache_lfu_refcount.sv.
`ifndef BLOCK_CACHE_LFU_REFCOUNT_MACROS_SVH
`define BLOCK_CACHE_LFU_REFCOUNT_MACROS_SVH

// Checked on the rising edge of clk, quiet while rst is high.
`define BCLFU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication form, same clock and reset.
`define BCLFU_ASSERT_IMP(label, ante, cons, msg) \
  `BCLFU_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication form.
`define BCLFU_ASSERT_NEXT(label, ante, cons, msg) \
  `BCLFU_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ hdl/bclfu_pkg.sv @@
`default_nettype none
package bclfu_pkg;

  localparam int IDX_W   = 8;   // wide enough for the largest entry count
  localparam int BLOCK_W = 32;
  localparam int HITS_W  = 32;
  localparam int REFS_W  = 8;
  localparam int DRV_W   = 2;
  localparam int SLOT_W  = 5;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 3;
  localparam int MASK_W  = 4;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [ACT_W-1:0] ACT_LOCK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UNLOCK = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACCESS = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;  // undefined action code

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNREF    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_HIT,
    OP_ALLOC,
    OP_UNLOCK,
    OP_ACCESS
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [DRV_W-1:0]   drive;
    logic [BLOCK_W-1:0] block_num;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  // Search record walking down the row of entries.
  typedef struct packed {
    logic              valid;
    logic              found;
    idx_t              hit_idx;
    logic              have;
    idx_t              best_idx;
    logic [HITS_W-1:0] best_hits;
    logic              sel_valid;
    logic [REFS_W-1:0] sel_refs;
    logic [DRV_W-1:0]  sel_drive;
    logic              sel_loaded;
  } carry_t;

  typedef struct packed {
    op_t  op;
    idx_t idx;
  } commit_t;

endpackage
`default_nettype wire

@@ hdl/block_cache_lfu_refcount.sv @@
`default_nettype none
// Tag store of a block buffer cache with least-frequently-used replacement.
// s_* channel: one request item. s_tuser = action (0 lock, 1 unlock,
// 2 access); s_tdata = drive, block_num, slot.
// m_* channel: one result item per request: slot_out, status, was_hit,
// fill_needed.
// cfg_*: write of drive_present_mask, always ready; write only while idle.
// Each entry sits in a cell of a row; a search record moves one cell per
// cycle, picking up the first tag match, the free entry with the lowest hit
// count and the addressed slot. The finished record then drives one update
// broadcast to the row and loads the output register.
// Request and launch flag are registered, the record passes the registered row
// cells and a record register, then the output register; a new item is taken only while idle.
// The output register holds a result while the receiver stalls, so the next
// item is accepted and searched meanwhile; its update waits until the
// register is free.
// Reset clears all entries (drive 0 block 0 matches at first), the mask and
// both channels.
module block_cache_lfu_refcount
  import bclfu_pkg::*;
#(
  parameter int ENTRIES = 32,
  parameter int DRIVES  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // drive[1:0], block_num[33:2], slot[38:34], zero
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // slot_out[4:0], status[7:5], was_hit[8],
                                      // fill_needed[9], zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data   // drive_present_mask
);

  state_t state, state_next;
  req_t   req;
  logic   launch;
  logic [MASK_W-1:0] mask;
  carry_t chain [ENTRIES+1];
  carry_t done_carry;
  commit_t commit;
  logic   accept;
  logic   out_load;

  logic [SLOT_W-1:0] r_slot;
  logic [STAT_W-1:0] r_status;
  logic              r_hit;
  logic              r_fill;
  op_t               r_op;
  idx_t              r_idx;
  logic              drive_ok;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_valid) begin
      mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.action    <= s_tuser;
      req.drive     <= s_tdata[1:0];
      req.block_num <= s_tdata[33:2];
      req.slot      <= s_tdata[38:34];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept;
    end
  end

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_row
    bclfu_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .req       (req),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1]),
      .commit    (commit)
    );
  end

  always_ff @(posedge clk) begin
    if (chain[ENTRIES].valid) begin
      done_carry <= chain[ENTRIES];
    end
  end

  // result decode from the finished search record
  assign drive_ok = (32'(req.drive) < DRIVES) && mask[req.drive];

  always_comb begin
    r_slot   = req.slot;
    r_status = ST_OK;
    r_hit    = 1'b0;
    r_fill   = 1'b0;
    r_op     = OP_NONE;
    r_idx    = idx_t'(req.slot);
    if ((req.action != ACT_NOP) && !drive_ok) begin
      r_status = ST_ABSENT;
    end else if (req.action == ACT_LOCK) begin
      if (done_carry.found) begin
        r_slot = SLOT_W'(done_carry.hit_idx);
        r_hit  = 1'b1;
        r_op   = OP_HIT;
        r_idx  = done_carry.hit_idx;
      end else if (done_carry.have) begin
        r_slot = SLOT_W'(done_carry.best_idx);
        r_op   = OP_ALLOC;
        r_idx  = done_carry.best_idx;
      end else begin
        r_status = ST_FULL;
      end
    end else if ((req.action == ACT_UNLOCK) || (req.action == ACT_ACCESS)) begin
      if (!done_carry.sel_valid || (done_carry.sel_refs == '0)) begin
        r_status = ST_UNREF;
      end else if (done_carry.sel_drive != req.drive) begin
        r_status = ST_MISMATCH;
      end else if (req.action == ACT_UNLOCK) begin
        r_op = OP_UNLOCK;
      end else begin
        r_op   = OP_ACCESS;
        r_fill = !done_carry.sel_loaded;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_SCAN;
      S_SCAN: if (chain[ENTRIES].valid) state_next = S_DONE;
      S_DONE: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    out_load   = 1'b0;
    commit.op  = OP_NONE;
    commit.idx = r_idx;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_SCAN: ;
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load  = 1'b1;
          commit.op = r_op;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, r_fill, r_hit, r_status, r_slot};
    end
  end

`include "block_cache_lfu_refcount_macros.svh"

  `BCLFU_ASSERT_IMP(a_idle_row_quiet, state == S_IDLE, !chain[ENTRIES].valid, "search record left the row while idle")
  `BCLFU_ASSERT_NEXT(a_accept_scans, accept, state == S_SCAN && launch, "accepted item did not start a search")
  `BCLFU_ASSERT_NEXT(a_load_shows, out_load, m_tvalid, "result loaded but not offered")
  `BCLFU_ASSERT_IMP(a_update_with_result, commit.op != OP_NONE, out_load, "row updated without a result being loaded")

endmodule
`default_nettype wire

@@ hdl/bclfu_cell.sv @@
`default_nettype none
module bclfu_cell
  import bclfu_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire req_t    req,
  input  wire carry_t  carry_in,
  output carry_t       carry_out,
  input  wire commit_t commit
);

  localparam idx_t MY_IDX = idx_t'(IDX);

  logic [DRV_W-1:0]   drive;
  logic [BLOCK_W-1:0] block_num;
  logic [REFS_W-1:0]  refs;
  logic [HITS_W-1:0]  hits;
  logic               loaded;

  carry_t carry_next;
  logic   match;
  logic   is_slot;
  logic   mine;

  assign match   = (block_num == req.block_num) && (drive == req.drive);
  assign is_slot = (idx_t'(req.slot) == MY_IDX);
  assign mine    = (commit.idx == MY_IDX);

  always_comb begin
    carry_next = carry_in;
    if (!carry_in.found && match) begin
      carry_next.found   = 1'b1;
      carry_next.hit_idx = MY_IDX;
    end
    // strict less-than keeps the lowest index on ties
    if ((refs == '0) && (!carry_in.have || (hits < carry_in.best_hits))) begin
      carry_next.have      = 1'b1;
      carry_next.best_idx  = MY_IDX;
      carry_next.best_hits = hits;
    end
    if (is_slot) begin
      carry_next.sel_valid  = 1'b1;
      carry_next.sel_refs   = refs;
      carry_next.sel_drive  = drive;
      carry_next.sel_loaded = loaded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.valid <= 1'b0;
    end else begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive     <= '0;
      block_num <= '0;
      refs      <= '0;
      hits      <= '0;
      loaded    <= 1'b0;
    end else if (mine) begin
      case (commit.op)
        OP_HIT: begin
          if (refs != '1) refs <= refs + 1'b1;
          if (hits != '1) hits <= hits + 1'b1;
        end
        OP_ALLOC: begin
          drive     <= req.drive;
          block_num <= req.block_num;
          refs      <= REFS_W'(1);
          hits      <= HITS_W'(1);
          loaded    <= 1'b0;
        end
        OP_UNLOCK: refs <= refs - 1'b1;
        OP_ACCESS: loaded <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
